// ===== design/hmef_pkg.sv =====
// ----------------------------------------------------------------------------
// HID mouse endpoint finder package
// Shared descriptor codes, match constants and the result record.
// ----------------------------------------------------------------------------
package hmef_pkg;

  localparam logic [7:0] DescTypeInterface = 8'h04;
  localparam logic [7:0] DescTypeEndpoint  = 8'h05;
  localparam logic [7:0] IfaceLenMin       = 8'd9;
  localparam logic [7:0] EpLenMin          = 8'd7;
  localparam logic [7:0] HidClass          = 8'h03;
  localparam logic [7:0] BootSubclass      = 8'h01;
  localparam logic [7:0] MouseProtocol     = 8'h02;
  localparam logic [7:0] EpDirIn           = 8'h80;
  localparam logic [1:0] XferInterrupt     = 2'b11;
  localparam logic [7:0] NoInterface       = 8'hFF;
  localparam logic [3:0] ConfigOffset      = 4'd5;
  localparam logic [3:0] MinStreamLen      = 4'd9;

  typedef struct packed {
    logic        found;
    logic [7:0]  config_value;
    logic [7:0]  interface_number;
    logic [3:0]  endpoint_number;
    logic [15:0] max_packet;
    logic [7:0]  poll_interval;
  } result_t;

endpackage

// ===== design/hid_mouse_endpoint_finder.sv =====
// ----------------------------------------------------------------------------
// HID mouse endpoint finder
// Scans a USB configuration descriptor set for a boot mouse interrupt IN
// endpoint and reports it when the final byte has been taken.
//
// Input channel (in_valid/in_ready): one descriptor byte per request, with
// last_byte set on the final byte of the set. Output channel
// (out_valid/out_ready): one result request per descriptor set, carrying
// found, the configuration value and the endpoint details.
// A byte is registered on acceptance and parsed in the following cycle, but
// a final byte waits while the result register is full; the result is also
// registered. The block takes one byte per cycle except while a final byte
// waits; the throughput is set by the single byte register before the parser.
// A stalled result holds only a final byte behind it; other bytes flow on.
// Reset clears both channels and puts the parser in its start state. After
// every final byte the parser returns to that state by itself.
// ----------------------------------------------------------------------------
module hid_mouse_endpoint_finder import hmef_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  desc_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [7:0]  config_value,
  output logic [7:0]  interface_number,
  output logic [3:0]  endpoint_number,
  output logic [15:0] max_packet,
  output logic [7:0]  poll_interval
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       held_last;
  logic       step;
  result_t    result;
  result_t    out_result;

  // A final byte may only be parsed once the result register is free.
  assign step     = held_valid && (!held_last || !out_valid || out_ready);
  assign in_ready = !held_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= desc_byte;
      held_last <= last_byte;
    end
  end

  hmef_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .byte_in (held_byte),
    .last_in (held_last),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && held_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && held_last) begin
      out_result <= result;
    end
  end

  assign found            = out_result.found;
  assign config_value     = out_result.config_value;
  assign interface_number = out_result.interface_number;
  assign endpoint_number  = out_result.endpoint_number;
  assign max_packet       = out_result.max_packet;
  assign poll_interval    = out_result.poll_interval;

endmodule

// ===== design/hmef_parse.sv =====
// ----------------------------------------------------------------------------
// HID mouse endpoint finder byte parser
// Holds the parse state and updates it for one descriptor byte per step.
// ----------------------------------------------------------------------------
module hmef_parse import hmef_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] byte_in,
  input  logic       last_in,
  output result_t    result
);

  logic [3:0]  stream_count, stream_count_next;
  logic [7:0]  desc_offset, desc_offset_next;
  logic [7:0]  desc_length, desc_length_next;
  logic [7:0]  desc_kind, desc_kind_next;
  logic        stopped, stopped_next;
  logic [7:0]  slot [5];
  logic [7:0]  slot_next [5];
  logic [7:0]  current_interface, current_interface_next;
  logic [7:0]  if_class, if_class_next;
  logic [7:0]  if_subclass, if_subclass_next;
  logic [7:0]  if_protocol, if_protocol_next;
  logic [7:0]  config_byte, config_byte_next;
  logic        match_latched, match_latched_next;
  logic [7:0]  m_iface, m_iface_next;
  logic [3:0]  m_ep, m_ep_next;
  logic [15:0] m_mps, m_mps_next;
  logic [7:0]  m_ival, m_ival_next;
  logic        parsing;
  logic        mouse_iface;
  logic [15:0] mps;

  assign mouse_iface = (current_interface != NoInterface) && (if_class == HidClass) &&
                       (if_subclass == BootSubclass) && (if_protocol == MouseProtocol);

  always_comb begin
    stream_count_next      = stream_count;
    desc_offset_next       = desc_offset;
    desc_length_next       = desc_length;
    desc_kind_next         = desc_kind;
    stopped_next           = stopped;
    slot_next              = slot;
    current_interface_next = current_interface;
    if_class_next          = if_class;
    if_subclass_next       = if_subclass;
    if_protocol_next       = if_protocol;
    config_byte_next       = config_byte;
    match_latched_next     = match_latched;
    m_iface_next           = m_iface;
    m_ep_next              = m_ep;
    m_mps_next             = m_mps;
    m_ival_next            = m_ival;
    parsing                = 1'b0;
    mps                    = '0;
    result                 = '0;

    if (step) begin
      if (stream_count == ConfigOffset) begin
        config_byte_next = byte_in;
      end
      if (!stopped) begin
        parsing = 1'b1;
        if (desc_offset == 8'd0) begin
          if (byte_in == 8'd0) begin
            stopped_next = 1'b1;
            parsing      = 1'b0;
          end else begin
            desc_length_next = byte_in;
            desc_kind_next   = 8'd0;
            for (int i = 0; i < 5; i++) begin
              slot_next[i] = 8'd0;
            end
          end
        end else if (desc_offset == 8'd1) begin
          desc_kind_next = byte_in;
        end else if (desc_kind == DescTypeInterface) begin
          case (desc_offset)
            8'd2:    slot_next[0] = byte_in;
            8'd5:    slot_next[1] = byte_in;
            8'd6:    slot_next[2] = byte_in;
            8'd7:    slot_next[3] = byte_in;
            default: ;
          endcase
        end else if (desc_kind == DescTypeEndpoint) begin
          case (desc_offset)
            8'd2:    slot_next[0] = byte_in;
            8'd3:    slot_next[1] = byte_in;
            8'd4:    slot_next[2] = byte_in;
            8'd5:    slot_next[3] = byte_in;
            8'd6:    slot_next[4] = byte_in;
            default: ;
          endcase
        end
      end

      if (parsing) begin
        if (desc_offset + 8'd1 == desc_length_next) begin
          desc_offset_next = 8'd0;
          // The descriptor closes on this byte, so evaluate it now.
          if (desc_kind_next == DescTypeInterface && desc_length_next >= IfaceLenMin) begin
            current_interface_next = slot_next[0];
            if_class_next          = slot_next[1];
            if_subclass_next       = slot_next[2];
            if_protocol_next       = slot_next[3];
          end else if (desc_kind_next == DescTypeEndpoint && desc_length_next >= EpLenMin &&
                       !match_latched) begin
            mps = {slot_next[3], slot_next[2]};
            if (mouse_iface && ((slot_next[0] & EpDirIn) != 8'd0) &&
                (slot_next[1][1:0] == XferInterrupt) && (mps != 16'd0)) begin
              match_latched_next = 1'b1;
              m_iface_next       = current_interface;
              m_ep_next          = slot_next[0][3:0];
              m_mps_next         = mps;
              m_ival_next        = slot_next[4];
            end
          end
        end else begin
          desc_offset_next = desc_offset + 8'd1;
        end
      end

      if (stream_count < MinStreamLen) begin
        stream_count_next = stream_count + 4'd1;
      end

      if (last_in) begin
        result.found        = match_latched_next && (stream_count_next >= MinStreamLen);
        result.config_value = config_byte_next;
        if (result.found) begin
          result.interface_number = m_iface_next;
          result.endpoint_number  = m_ep_next;
          result.max_packet       = m_mps_next;
          result.poll_interval    = m_ival_next;
        end
        // The stream is over; start clean for the next descriptor set.
        stream_count_next      = '0;
        desc_offset_next       = '0;
        desc_length_next       = '0;
        desc_kind_next         = '0;
        stopped_next           = 1'b0;
        for (int i = 0; i < 5; i++) begin
          slot_next[i] = 8'd0;
        end
        current_interface_next = NoInterface;
        if_class_next          = '0;
        if_subclass_next       = '0;
        if_protocol_next       = '0;
        config_byte_next       = '0;
        match_latched_next     = 1'b0;
        m_iface_next           = '0;
        m_ep_next              = '0;
        m_mps_next             = '0;
        m_ival_next            = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_count      <= '0;
      desc_offset       <= '0;
      desc_length       <= '0;
      desc_kind         <= '0;
      stopped           <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        slot[i] <= 8'd0;
      end
      current_interface <= NoInterface;
      if_class          <= '0;
      if_subclass       <= '0;
      if_protocol       <= '0;
      config_byte       <= '0;
      match_latched     <= 1'b0;
      m_iface           <= '0;
      m_ep              <= '0;
      m_mps             <= '0;
      m_ival            <= '0;
    end else begin
      stream_count      <= stream_count_next;
      desc_offset       <= desc_offset_next;
      desc_length       <= desc_length_next;
      desc_kind         <= desc_kind_next;
      stopped           <= stopped_next;
      slot              <= slot_next;
      current_interface <= current_interface_next;
      if_class          <= if_class_next;
      if_subclass       <= if_subclass_next;
      if_protocol       <= if_protocol_next;
      config_byte       <= config_byte_next;
      match_latched     <= match_latched_next;
      m_iface           <= m_iface_next;
      m_ep              <= m_ep_next;
      m_mps             <= m_mps_next;
      m_ival            <= m_ival_next;
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HID mouse endpoint finder testbench
// Streams configuration descriptor sets into the finder, byte by byte, and
// checks each report against a behavioral copy of the parser. Both channels
// idle at random, and the receiver once holds off long enough to back up
// the input.
// ----------------------------------------------------------------------------
module testbench;
  import hmef_pkg::*;

  localparam logic [7:0] CfgDescType = 8'h02;
  localparam logic [7:0] HidDescType = 8'h21;
  localparam int         ByteTarget  = 1750;
  localparam int         HoldReport  = 3;
  localparam int         HoldCycles  = 4000;

  // Behavioral copy of the parser, with the queue of reports it predicts.
  class EndpointScan;
    logic [3:0] byte_count;
    logic [7:0] offset;
    logic [7:0] length;
    logic [7:0] kind;
    logic       halted;
    logic [7:0] fields [5];
    logic [7:0] iface;
    logic [7:0] cur_class;
    logic [7:0] cur_subclass;
    logic [7:0] cur_protocol;
    logic [7:0] seen_config;
    logic       latched;
    result_t    hit;
    result_t    expected_reports[$];
    int         reports_made;
    int         errors;

    function new();
      clear();
      reports_made = 0;
      errors = 0;
    endfunction

    function void clear();
      byte_count = '0;
      offset = '0;
      length = '0;
      kind = '0;
      halted = 1'b0;
      foreach (fields[i]) fields[i] = '0;
      iface = NoInterface;
      cur_class = '0;
      cur_subclass = '0;
      cur_protocol = '0;
      seen_config = '0;
      latched = 1'b0;
      hit = '0;
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      logic [15:0] mps;
      result_t     rep;
      if (byte_count == ConfigOffset) seen_config = b;
      if (!halted) begin
        if (offset == 8'd0) begin
          if (b == 8'd0) begin
            halted = 1'b1;
          end else begin
            length = b;
            kind = '0;
            foreach (fields[i]) fields[i] = '0;
          end
        end else if (offset == 8'd1) begin
          kind = b;
        end else if (kind == DescTypeInterface) begin
          if (offset == 8'd2) fields[0] = b;
          else if (offset >= 8'd5 && offset <= 8'd7) fields[offset - 8'd4] = b;
        end else if (kind == DescTypeEndpoint) begin
          if (offset <= 8'd6) fields[offset - 8'd2] = b;
        end
        // A zero length byte stops the parser where it stands.
        if (!halted) begin
          if ({1'b0, offset} + 9'd1 == {1'b0, length}) begin
            if (kind == DescTypeInterface && length >= IfaceLenMin) begin
              iface = fields[0];
              cur_class = fields[1];
              cur_subclass = fields[2];
              cur_protocol = fields[3];
            end else if (kind == DescTypeEndpoint && length >= EpLenMin && !latched) begin
              mps = {fields[3], fields[2]};
              if (iface != NoInterface && cur_class == HidClass &&
                  cur_subclass == BootSubclass && cur_protocol == MouseProtocol &&
                  (fields[0] & EpDirIn) != 8'd0 && fields[1][1:0] == XferInterrupt &&
                  mps != 16'd0) begin
                latched = 1'b1;
                hit.interface_number = iface;
                hit.endpoint_number = fields[0][3:0];
                hit.max_packet = mps;
                hit.poll_interval = fields[4];
              end
            end
            offset = '0;
          end else begin
            offset = offset + 8'd1;
          end
        end
      end
      if (byte_count < MinStreamLen) byte_count = byte_count + 4'd1;
      if (last) begin
        rep = '0;
        rep.found = latched && byte_count >= MinStreamLen;
        rep.config_value = seen_config;
        if (rep.found) begin
          rep.interface_number = hit.interface_number;
          rep.endpoint_number = hit.endpoint_number;
          rep.max_packet = hit.max_packet;
          rep.poll_interval = hit.poll_interval;
        end
        expected_reports.push_back(rep);
        reports_made++;
        clear();
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_report(result_t got);
      result_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: report with none expected, got %h", $time, got);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      compare_field("found", 16'(want.found), 16'(got.found));
      compare_field("config_value", 16'(want.config_value), 16'(got.config_value));
      compare_field("interface_number", 16'(want.interface_number),
                    16'(got.interface_number));
      compare_field("endpoint_number", 16'(want.endpoint_number),
                    16'(got.endpoint_number));
      compare_field("max_packet", want.max_packet, got.max_packet);
      compare_field("poll_interval", 16'(want.poll_interval), 16'(got.poll_interval));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  desc_byte = '0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        found;
  logic [7:0]  config_value;
  logic [7:0]  interface_number;
  logic [3:0]  endpoint_number;
  logic [15:0] max_packet;
  logic [7:0]  poll_interval;

  EndpointScan scan = new();
  logic [7:0]  set_bytes[$];

  hid_mouse_endpoint_finder dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .desc_byte        (desc_byte),
    .last_byte        (last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .found            (found),
    .config_value     (config_value),
    .interface_number (interface_number),
    .endpoint_number  (endpoint_number),
    .max_packet       (max_packet),
    .poll_interval    (poll_interval)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Appends one sub-descriptor; the body holds the bytes after the type,
  // first byte in the top lane, and anything past it is random padding.
  task automatic put_desc(input logic [7:0] len, input logic [7:0] kind,
                          input logic [55:0] body);
    set_bytes.push_back(len);
    if (len >= 8'd2) set_bytes.push_back(kind);
    for (int i = 2; i < int'(len); i++) begin
      if (i - 2 < 7) set_bytes.push_back(body[55 - 8 * (i - 2) -: 8]);
      else set_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic build_random_set();
    int          n_if;
    int          cut;
    logic [7:0]  len;
    logic [7:0]  num;
    logic [23:0] triple;
    logic [7:0]  addr;
    logic [7:0]  attrs;
    logic [15:0] mps;
    set_bytes.delete();
    // Some sets are plain noise, often too short to report a match.
    if ($urandom_range(0, 9) < 3) begin
      repeat ($urandom_range(1, 20)) set_bytes.push_back(8'($urandom));
      return;
    end
    put_desc(IfaceLenMin, CfgDescType, 56'({$urandom, $urandom}));
    n_if = $urandom_range(1, 3);
    for (int k = 0; k < n_if; k++) begin
      case ($urandom_range(0, 19))
        0: set_bytes.push_back(8'd0);
        1: set_bytes.push_back(8'd1);
        2: put_desc(8'($urandom_range(2, 12)), 8'($urandom), 56'({$urandom, $urandom}));
        default: ;
      endcase
      case ($urandom_range(0, 7))
        0: len = IfaceLenMin - 8'd1;
        1: len = 8'($urandom_range(10, 14));
        default: len = IfaceLenMin;
      endcase
      num = ($urandom_range(0, 15) == 0) ? NoInterface : 8'($urandom);
      triple = {HidClass, BootSubclass, MouseProtocol};
      if ($urandom_range(0, 9) >= 6) begin
        case ($urandom_range(0, 3))
          0: triple[23:16] = 8'($urandom);
          1: triple[15:8] = 8'($urandom);
          2: triple[7:0] = 8'($urandom);
          default: triple = 24'($urandom);
        endcase
      end
      put_desc(len, DescTypeInterface,
               {num, 16'($urandom), triple, 8'($urandom)});
      if ($urandom_range(0, 1) == 1) put_desc(IfaceLenMin, HidDescType,
                                             56'({$urandom, $urandom}));
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 7))
          0: len = EpLenMin - 8'd1;
          1: len = 8'($urandom_range(8, 10));
          default: len = EpLenMin;
        endcase
        addr = 8'($urandom);
        if ($urandom_range(0, 3) != 0) addr = addr | EpDirIn;
        attrs = 8'($urandom);
        if ($urandom_range(0, 3) != 0) attrs[1:0] = XferInterrupt;
        case ($urandom_range(0, 9))
          0: mps = 16'd0;
          1: mps = 16'hFFFF;
          2, 3: mps = 16'($urandom);
          default: mps = 16'($urandom_range(1, 64));
        endcase
        put_desc(len, DescTypeEndpoint,
                 {addr, attrs, mps[7:0], mps[15:8], 8'($urandom), 16'($urandom)});
      end
    end
    // Now and then the set loses up to eight trailing bytes and may end partway through a descriptor.
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, (set_bytes.size() - 1 < 8) ? set_bytes.size() - 1 : 8);
      repeat (cut) void'(set_bytes.pop_back());
    end
  endtask

  // Sends the queued set, one request per byte, last_byte on the final one.
  task automatic send_set(input bit lazy);
    int gap;
    for (int i = 0; i < set_bytes.size(); i++) begin
      gap = lazy ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      desc_byte <= set_bytes[i];
      last_byte <= (i == set_bytes.size() - 1);
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      scan.take_byte(set_bytes[i], i == set_bytes.size() - 1);
    end
  endtask

  initial begin
    int sent;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // A lone zero length byte: parsing stops and the stream is short.
    set_bytes = '{8'h00};
    send_set(1'b1);
    // A boot mouse with extreme endpoint fields, a length one descriptor and
    // a second match that must not replace the first.
    set_bytes = '{IfaceLenMin, DescTypeInterface, 8'h00, 8'h00, 8'h01, HidClass,
                  BootSubclass, MouseProtocol, 8'h00,
                  EpLenMin, DescTypeEndpoint, 8'h8F, 8'h03, 8'hFF, 8'hFF, 8'hFF,
                  8'h01,
                  EpLenMin, DescTypeEndpoint, 8'h81, 8'h03, 8'h08, 8'h00, 8'h0A};
    send_set(1'b0);
    sent = 25;
    while (sent < ByteTarget) begin
      build_random_set();
      sent += set_bytes.size();
      send_set($urandom_range(0, 2) != 0);
    end
    in_valid <= 1'b0;
    while (scan.expected_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (scan.errors == 0) begin
      $display("** hid_mouse_endpoint_finder: PASSED **");
    end else begin
      $display("** hid_mouse_endpoint_finder: FAILED **");
    end
    $finish;
  end

  initial begin
    int      stall;
    int      taken;
    bit      steady;
    result_t got;
    taken = 0;
    steady = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (taken % 6 == 0) steady = ($urandom_range(0, 2) == 0);
      stall = steady ? 0 : $urandom_range(0, 17);
      // Sometimes let the report wait before the stall starts counting.
      if (taken == HoldReport || (!steady && $urandom_range(0, 1) == 1)) begin
        out_ready <= 1'b0;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
      end
      if (taken == HoldReport) stall = HoldCycles;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.found = found;
      got.config_value = config_value;
      got.interface_number = interface_number;
      got.endpoint_number = endpoint_number;
      got.max_packet = max_packet;
      got.poll_interval = poll_interval;
      scan.check_report(got);
      taken++;
    end
  end

  initial begin
    #5000000;
    $display("** hid_mouse_endpoint_finder: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/hmef_pkg.sv
design/hmef_parse.sv
design/hid_mouse_endpoint_finder.sv
tb/testbench.sv
